@@ design/eavr_pkg.sv @@
package eavr_pkg;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [31:0] nav_x;
		logic signed [31:0] nav_y;
		logic signed [31:0] nav_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] body_x;
		logic signed [31:0] body_y;
		logic signed [31:0] body_z;
	} rsp_t;

	// direction cosine matrix, Q30
	typedef struct packed {
		logic signed [33:0] m0;
		logic signed [33:0] m1;
		logic signed [33:0] m2;
		logic signed [33:0] m3;
		logic signed [33:0] m4;
		logic signed [33:0] m5;
		logic signed [33:0] m6;
		logic signed [33:0] m7;
		logic signed [33:0] m8;
	} dcm_t;

	localparam logic signed [16:0] FULL_TURN    = 17'sd46080;
	localparam logic [15:0]        QUARTER_1    = 16'd11520;
	localparam logic [15:0]        QUARTER_2    = 16'd23040;
	localparam logic [15:0]        QUARTER_3    = 16'd34560;
	localparam logic [13:0]        QUARTER_TURN = 14'd11520;
	localparam logic [13:0]        EIGHTH_TURN  = 14'd5760;
	localparam logic [30:0]        RAD_PER_UNIT = 31'd146409;
	localparam logic [30:0]        ONE_Q30      = 31'h4000_0000;

	// exact reciprocals: floor(v/d) = (v*R) >> K for any 30-bit v
	localparam int unsigned    SHIFT_72 = 37;
	localparam int unsigned    SHIFT_42 = 36;
	localparam int unsigned    SHIFT_20 = 35;
	localparam int unsigned    SHIFT_6  = 33;
	localparam int unsigned    SHIFT_90 = 37;
	localparam int unsigned    SHIFT_56 = 36;
	localparam int unsigned    SHIFT_30 = 35;
	localparam int unsigned    SHIFT_12 = 34;
	localparam logic [30:0] RECIP_72 = 31'(((64'd1 << 37) + 64'd71) / 64'd72);
	localparam logic [30:0] RECIP_42 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
	localparam logic [30:0] RECIP_20 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
	localparam logic [30:0] RECIP_6  = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
	localparam logic [30:0] RECIP_90 = 31'(((64'd1 << 37) + 64'd89) / 64'd90);
	localparam logic [30:0] RECIP_56 = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
	localparam logic [30:0] RECIP_30 = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
	localparam logic [30:0] RECIP_12 = 31'(((64'd1 << 34) + 64'd11) / 64'd12);

	// Horner step: one minus the quotient of v by a constant
	function automatic logic [30:0] one_minus_div(input logic [29:0] v,
		input logic [30:0] recip, input int unsigned shift);
		logic [60:0] p;
		p = 61'(v) * 61'(recip);
		return ONE_Q30 - 31'(p >> shift);
	endfunction

	function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
		logic [60:0] p;
		p = 61'(a) * 61'(b);
		return 30'(p >> 30);
	endfunction

	// round half up from Q30 to Q15 and cap
	function automatic logic [15:0] to_q15(input logic [30:0] v);
		logic [31:0] q;
		q = (32'(v) + 32'h4000) >> 15;
		return (q > 32'd32767) ? 16'h7fff : q[15:0];
	endfunction

endpackage

@@ design/eavr_trig.sv @@
module eavr_trig #(
	parameter bit NEG = 1'b0
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] angle,
	output logic signed [15:0] sin_val,
	output logic signed [15:0] cos_val
);

	logic signed [16:0] a_w;
	logic [15:0]        m_w;
	logic [13:0]        r_w;
	logic [1:0]         quad_w;

	logic [12:0] rr_s1;
	logic [29:0] x_s [2:10];
	logic [1:0]  quad_s [1:11];
	logic        swap_s [1:11];
	logic [29:0] x2_s3, x2_s4, x2_s5, x2_s6, x2_s7, x2_s8, x2_s9, x2_s10;
	logic [30:0] ts_s4, ts_s6, ts_s8, ts_s10;
	logic [30:0] tc_s4, tc_s6, tc_s8, tc_s10;
	logic [29:0] ps_s5, ps_s7, ps_s9, sv_s11;
	logic [29:0] pc_s5, pc_s7, pc_s9, pc_s11;
	logic signed [15:0] sin_s12, cos_s12;

	logic [15:0] s0_w, c0_w, so_w, co_w;

	// reduce to one turn and split quadrant; the stage 1 register folds the upper octant
	always_comb begin
		a_w = NEG ? -17'(angle) : 17'(angle);
		m_w = a_w[16] ? 16'(a_w + eavr_pkg::FULL_TURN) : 16'(a_w);
		if (m_w >= eavr_pkg::QUARTER_3) begin
			quad_w = 2'd3;
			r_w    = 14'(m_w - eavr_pkg::QUARTER_3);
		end else if (m_w >= eavr_pkg::QUARTER_2) begin
			quad_w = 2'd2;
			r_w    = 14'(m_w - eavr_pkg::QUARTER_2);
		end else if (m_w >= eavr_pkg::QUARTER_1) begin
			quad_w = 2'd1;
			r_w    = 14'(m_w - eavr_pkg::QUARTER_1);
		end else begin
			quad_w = 2'd0;
			r_w    = 14'(m_w);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (r_w > eavr_pkg::EIGHTH_TURN) begin
				rr_s1     <= 13'(eavr_pkg::QUARTER_TURN - r_w);
				swap_s[1] <= 1'b1;
			end else begin
				rr_s1     <= 13'(r_w);
				swap_s[1] <= 1'b0;
			end
			quad_s[1] <= quad_w;
			for (int i = 2; i <= 11; i++) begin
				quad_s[i] <= quad_s[i-1];
				swap_s[i] <= swap_s[i-1];
			end
			x_s[2] <= 30'(31'(rr_s1) * eavr_pkg::RAD_PER_UNIT);
			for (int i = 3; i <= 10; i++)
				x_s[i] <= x_s[i-1];
			x2_s3 <= 30'((60'(x_s[2]) * 60'(x_s[2])) >> 30);

			x2_s4 <= x2_s3;
			ts_s4 <= eavr_pkg::one_minus_div(x2_s3, eavr_pkg::RECIP_72, eavr_pkg::SHIFT_72);
			tc_s4 <= eavr_pkg::one_minus_div(x2_s3, eavr_pkg::RECIP_90, eavr_pkg::SHIFT_90);

			x2_s5 <= x2_s4;
			ps_s5 <= eavr_pkg::mul_q30(x2_s4, ts_s4);
			pc_s5 <= eavr_pkg::mul_q30(x2_s4, tc_s4);

			x2_s6 <= x2_s5;
			ts_s6 <= eavr_pkg::one_minus_div(ps_s5, eavr_pkg::RECIP_42, eavr_pkg::SHIFT_42);
			tc_s6 <= eavr_pkg::one_minus_div(pc_s5, eavr_pkg::RECIP_56, eavr_pkg::SHIFT_56);

			x2_s7 <= x2_s6;
			ps_s7 <= eavr_pkg::mul_q30(x2_s6, ts_s6);
			pc_s7 <= eavr_pkg::mul_q30(x2_s6, tc_s6);

			x2_s8 <= x2_s7;
			ts_s8 <= eavr_pkg::one_minus_div(ps_s7, eavr_pkg::RECIP_20, eavr_pkg::SHIFT_20);
			tc_s8 <= eavr_pkg::one_minus_div(pc_s7, eavr_pkg::RECIP_30, eavr_pkg::SHIFT_30);

			x2_s9 <= x2_s8;
			ps_s9 <= eavr_pkg::mul_q30(x2_s8, ts_s8);
			pc_s9 <= eavr_pkg::mul_q30(x2_s8, tc_s8);

			x2_s10 <= x2_s9;
			ts_s10 <= eavr_pkg::one_minus_div(ps_s9, eavr_pkg::RECIP_6, eavr_pkg::SHIFT_6);
			tc_s10 <= eavr_pkg::one_minus_div(pc_s9, eavr_pkg::RECIP_12, eavr_pkg::SHIFT_12);

			sv_s11 <= eavr_pkg::mul_q30(x_s[10], ts_s10);
			pc_s11 <= eavr_pkg::mul_q30(x2_s10, tc_s10);

			sin_s12 <= signed'(so_w);
			cos_s12 <= signed'(co_w);
		end
	end

	// finish cosine (divide by two is a shift), round, unfold, apply quadrant
	always_comb begin
		s0_w = eavr_pkg::to_q15(31'(sv_s11));
		c0_w = eavr_pkg::to_q15(eavr_pkg::ONE_Q30 - 31'(pc_s11 >> 1));
		if (swap_s[11]) begin
			so_w = c0_w;
			co_w = s0_w;
		end else begin
			so_w = s0_w;
			co_w = c0_w;
		end
		case (quad_s[11])
			2'd0: begin
				so_w = so_w;
				co_w = co_w;
			end
			2'd1: begin
				{so_w, co_w} = {co_w, -so_w};
			end
			2'd2: begin
				{so_w, co_w} = {-so_w, -co_w};
			end
			default: begin
				{so_w, co_w} = {-co_w, so_w};
			end
		endcase
	end

	assign sin_val = sin_s12;
	assign cos_val = cos_s12;

endmodule

@@ design/eavr_dcm.sv @@
module eavr_dcm (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] sr,
	input  logic signed [15:0] cr,
	input  logic signed [15:0] sp,
	input  logic signed [15:0] cp,
	input  logic signed [15:0] sy,
	input  logic signed [15:0] cy,
	output eavr_pkg::dcm_t     dcm
);

	logic signed [31:0] cp_cy_s1, cp_sy_s1, cr_sy_s1, cr_cy_s1, sr_cp_s1;
	logic signed [31:0] sr_sy_s1, cr_cp_s1, sr_cy_s1, sp_sr_s1, cr_sp_s1;
	logic signed [15:0] sp_s1, sy_s1, cy_s1;

	logic signed [31:0] cp_cy_s2, cp_sy_s2, cr_sy_s2, cr_cy_s2, sr_cp_s2;
	logic signed [31:0] sr_sy_s2, cr_cp_s2, sr_cy_s2;
	logic signed [15:0] sp_s2;
	logic signed [33:0] t3_s2, t4_s2, t6_s2, t7_s2;

	eavr_pkg::dcm_t dcm_s3;

	// triple product rounded half up from Q45 to Q30
	function automatic logic signed [33:0] tri_round(input logic signed [31:0] ab,
		input logic signed [15:0] c);
		logic signed [47:0] p;
		p = 48'(ab) * 48'(c);
		return 34'((p + 48'sd16384) >>> 15);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cp_cy_s1 <= 32'(cp) * 32'(cy);
			cp_sy_s1 <= 32'(cp) * 32'(sy);
			cr_sy_s1 <= 32'(cr) * 32'(sy);
			cr_cy_s1 <= 32'(cr) * 32'(cy);
			sr_cp_s1 <= 32'(sr) * 32'(cp);
			sr_sy_s1 <= 32'(sr) * 32'(sy);
			cr_cp_s1 <= 32'(cr) * 32'(cp);
			sr_cy_s1 <= 32'(sr) * 32'(cy);
			sp_sr_s1 <= 32'(sp) * 32'(sr);
			cr_sp_s1 <= 32'(cr) * 32'(sp);
			sp_s1    <= sp;
			sy_s1    <= sy;
			cy_s1    <= cy;

			cp_cy_s2 <= cp_cy_s1;
			cp_sy_s2 <= cp_sy_s1;
			cr_sy_s2 <= cr_sy_s1;
			cr_cy_s2 <= cr_cy_s1;
			sr_cp_s2 <= sr_cp_s1;
			sr_sy_s2 <= sr_sy_s1;
			cr_cp_s2 <= cr_cp_s1;
			sr_cy_s2 <= sr_cy_s1;
			sp_s2    <= sp_s1;
			t3_s2    <= tri_round(sp_sr_s1, cy_s1);
			t4_s2    <= tri_round(sp_sr_s1, sy_s1);
			t6_s2    <= tri_round(cr_sp_s1, cy_s1);
			t7_s2    <= tri_round(cr_sp_s1, sy_s1);

			dcm_s3.m0 <= 34'(cp_cy_s2);
			dcm_s3.m1 <= 34'(cp_sy_s2);
			dcm_s3.m2 <= -(34'(sp_s2) <<< 15);
			dcm_s3.m3 <= t3_s2 - 34'(cr_sy_s2);
			dcm_s3.m4 <= 34'(cr_cy_s2) + t4_s2;
			dcm_s3.m5 <= 34'(sr_cp_s2);
			dcm_s3.m6 <= 34'(sr_sy_s2) + t6_s2;
			dcm_s3.m7 <= t7_s2 - 34'(sr_cy_s2);
			dcm_s3.m8 <= 34'(cr_cp_s2);
		end
	end

	assign dcm = dcm_s3;

endmodule

@@ design/eavr_dot.sv @@
module eavr_dot (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] m0,
	input  logic signed [33:0] m1,
	input  logic signed [33:0] m2,
	input  logic signed [31:0] v0,
	input  logic signed [31:0] v1,
	input  logic signed [31:0] v2,
	output logic signed [31:0] dot
);

	logic signed [50:0] p0_s1, p1_s1, p2_s1;
	logic signed [52:0] acc_s2;
	logic signed [37:0] rnd_w;
	logic signed [31:0] dot_s3;

	function automatic logic signed [50:0] prod_round(input logic signed [33:0] m,
		input logic signed [31:0] v);
		logic signed [65:0] p;
		p = 66'(m) * 66'(v);
		return 51'((p + 66'sd16384) >>> 15);
	endfunction

	assign rnd_w = 38'((acc_s2 + 53'sd16384) >>> 15);

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1  <= prod_round(m0, v0);
			p1_s1  <= prod_round(m1, v1);
			p2_s1  <= prod_round(m2, v2);
			acc_s2 <= 53'(p0_s1) + 53'(p1_s1) + 53'(p2_s1);
			// saturate to 32 bits
			if (rnd_w > 38'sd2147483647)
				dot_s3 <= 32'sh7fff_ffff;
			else if (rnd_w < -38'sd2147483648)
				dot_s3 <= 32'sh8000_0000;
			else
				dot_s3 <= 32'(rnd_w);
		end
	end

	assign dot = dot_s3;

endmodule

@@ design/euler_attitude_vector_rotate.sv @@
// Euler ZYX attitude vector rotation: navigation-frame vector to body frame.
// Request channel (req_valid/req_ready/req_data) carries roll, pitch and yaw
// in 1/128 degree and a Q16.16 vector; response channel (rsp_valid/rsp_ready/
// rsp_data) returns the saturated Q16.16 body-frame vector, one per request.
// The pipeline is 18 register stages: 12 for the sine/cosine series (reduce,
// scale, square, then alternating reciprocal-divide and multiply Horner steps,
// then round, unfold and apply quadrant), 3 for the direction cosine matrix,
// 3 for the row products, sum and saturate. One transaction enters per cycle
// while the response side takes results.
// All stages advance together: when the last stage holds a result that is
// not taken, the whole pipeline holds and req_ready drops in the same cycle;
// nothing is dropped or repeated. Reset clears the stage valid bits, so the
// block comes out of reset empty and ready.
module euler_attitude_vector_rotate (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  eavr_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output eavr_pkg::rsp_t rsp_data
);

	localparam int TRIG_STAGES = 12;
	localparam int DCM_STAGES  = 3;
	localparam int DOT_STAGES  = 3;
	localparam int VEC_STAGES  = TRIG_STAGES + DCM_STAGES;
	localparam int ALL_STAGES  = VEC_STAGES + DOT_STAGES;

	logic en;
	logic valid_s [1:ALL_STAGES];
	logic signed [31:0] vx_s [1:VEC_STAGES];
	logic signed [31:0] vy_s [1:VEC_STAGES];
	logic signed [31:0] vz_s [1:VEC_STAGES];

	logic signed [15:0] sr, cr, sp, cp, sy, cy;
	eavr_pkg::dcm_t dcm;

	// advance unless the output holds an untaken result
	assign en        = !valid_s[ALL_STAGES] || rsp_ready;
	assign req_ready = en;
	assign rsp_valid = valid_s[ALL_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= ALL_STAGES; i++)
				valid_s[i] <= 1'b0;
		end else if (en) begin
			valid_s[1] <= req_valid;
			for (int i = 2; i <= ALL_STAGES; i++)
				valid_s[i] <= valid_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s[1] <= req_data.nav_x;
			vy_s[1] <= req_data.nav_y;
			vz_s[1] <= req_data.nav_z;
			for (int i = 2; i <= VEC_STAGES; i++) begin
				vx_s[i] <= vx_s[i-1];
				vy_s[i] <= vy_s[i-1];
				vz_s[i] <= vz_s[i-1];
			end
		end
	end

	eavr_trig #(.NEG(1'b1)) u_roll (
		.clk(clk), .en(en), .angle(req_data.roll_angle), .sin_val(sr), .cos_val(cr)
	);
	eavr_trig #(.NEG(1'b1)) u_pitch (
		.clk(clk), .en(en), .angle(req_data.pitch_angle), .sin_val(sp), .cos_val(cp)
	);
	eavr_trig #(.NEG(1'b0)) u_yaw (
		.clk(clk), .en(en), .angle(req_data.yaw_angle), .sin_val(sy), .cos_val(cy)
	);

	eavr_dcm u_dcm (
		.clk(clk), .en(en),
		.sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
		.dcm(dcm)
	);

	eavr_dot u_dot_x (
		.clk(clk), .en(en), .m0(dcm.m0), .m1(dcm.m1), .m2(dcm.m2),
		.v0(vx_s[VEC_STAGES]), .v1(vy_s[VEC_STAGES]), .v2(vz_s[VEC_STAGES]),
		.dot(rsp_data.body_x)
	);
	eavr_dot u_dot_y (
		.clk(clk), .en(en), .m0(dcm.m3), .m1(dcm.m4), .m2(dcm.m5),
		.v0(vx_s[VEC_STAGES]), .v1(vy_s[VEC_STAGES]), .v2(vz_s[VEC_STAGES]),
		.dot(rsp_data.body_y)
	);
	eavr_dot u_dot_z (
		.clk(clk), .en(en), .m0(dcm.m6), .m1(dcm.m7), .m2(dcm.m8),
		.v0(vx_s[VEC_STAGES]), .v1(vy_s[VEC_STAGES]), .v2(vz_s[VEC_STAGES]),
		.dot(rsp_data.body_z)
	);

endmodule

@@ test/tb_euler_attitude_vector_rotate.sv @@
module tb_euler_attitude_vector_rotate;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	eavr_pkg::req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	eavr_pkg::rsp_t rsp_data;

	eavr_pkg::req_t pending_req[$];
	eavr_pkg::rsp_t expected_body[$];
	int   error_count;
	int   idle_cycles;
	int   results_seen;
	logic req_taken;
	logic rsp_taken;
	int   send_gap;
	int   recv_wait;
	int   long_hold;
	logic long_hold_done;
	logic zero_gap_mode;

	euler_attitude_vector_rotate u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint unsigned q30_to_q15(input longint unsigned v);
		longint unsigned q;
		q = (v + 64'd16384) >> 15;
		if (q > 64'd32767)
			q = 64'd32767;
		return q;
	endfunction

	// sine and cosine over the first octant, Q15
	function automatic void octant_trig(input int r, output longint s, output longint c);
		longint unsigned x, x2, t, one;
		one = 64'd1 << 30;
		x  = longint'(r) * 64'd146409;
		x2 = (x * x) >> 30;
		t = one - x2 / 72;
		t = one - ((x2 * t) >> 30) / 42;
		t = one - ((x2 * t) >> 30) / 20;
		t = one - ((x2 * t) >> 30) / 6;
		s = longint'(q30_to_q15((x * t) >> 30));
		t = one - x2 / 90;
		t = one - ((x2 * t) >> 30) / 56;
		t = one - ((x2 * t) >> 30) / 30;
		t = one - ((x2 * t) >> 30) / 12;
		t = one - ((x2 * t) >> 30) / 2;
		c = longint'(q30_to_q15(t));
	endfunction

	function automatic void angle_trig(input int a, output longint s, output longint c);
		int m, quad, r;
		longint s0, c0;
		m = ((a % 46080) + 46080) % 46080;
		quad = m / 11520;
		r = m % 11520;
		if (r <= 5760)
			octant_trig(r, s0, c0);
		else
			octant_trig(11520 - r, c0, s0);
		case (quad)
			0: begin s = s0;  c = c0;  end
			1: begin s = c0;  c = -s0; end
			2: begin s = -s0; c = -c0; end
			default: begin s = -c0; c = s0; end
		endcase
	endfunction

	function automatic longint triple_q30(input longint a, input longint b, input longint c);
		return (a * b * c + (64'sd1 <<< 14)) >>> 15;
	endfunction

	function automatic logic signed [31:0] row_dot(input longint m0, input longint m1,
		input longint m2, input longint v0, input longint v1, input longint v2);
		longint acc;
		longint half;
		half = 64'sd1 <<< 14;
		acc = ((m0 * v0 + half) >>> 15) + ((m1 * v1 + half) >>> 15)
			+ ((m2 * v2 + half) >>> 15);
		acc = (acc + half) >>> 15;
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		return acc[31:0];
	endfunction

	function automatic eavr_pkg::rsp_t rotate_to_body(input eavr_pkg::req_t q);
		longint sr, cr, sp, cp, sy, cy;
		longint m[9];
		longint vx, vy, vz;
		eavr_pkg::rsp_t o;
		angle_trig(-int'(q.roll_angle), sr, cr);
		angle_trig(-int'(q.pitch_angle), sp, cp);
		angle_trig(int'(q.yaw_angle), sy, cy);
		m[0] = cp * cy;
		m[1] = cp * sy;
		m[2] = -sp * 32768;
		m[3] = -cr * sy + triple_q30(sp, sr, cy);
		m[4] = cr * cy + triple_q30(sr, sp, sy);
		m[5] = sr * cp;
		m[6] = sr * sy + triple_q30(cr, sp, cy);
		m[7] = -sr * cy + triple_q30(cr, sp, sy);
		m[8] = cr * cp;
		vx = longint'(q.nav_x);
		vy = longint'(q.nav_y);
		vz = longint'(q.nav_z);
		o.body_x = row_dot(m[0], m[1], m[2], vx, vy, vz);
		o.body_y = row_dot(m[3], m[4], m[5], vx, vy, vz);
		o.body_z = row_dot(m[6], m[7], m[8], vx, vy, vz);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
		error_count++;
	endtask

	task automatic add_item(input int r, input int p, input int y,
		input int x, input int yv, input int z);
		eavr_pkg::req_t q;
		q.roll_angle  = 16'(r);
		q.pitch_angle = 16'(p);
		q.yaw_angle   = 16'(y);
		q.nav_x       = 32'(x);
		q.nav_y       = 32'(yv);
		q.nav_z       = 32'(z);
		pending_req.push_back(q);
	endtask

	function automatic logic [15:0] random_angle();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 8) * 5760 - 23040 + $urandom_range(0, 2) - 1);
			default: return 16'($urandom_range(0, 46080) - 23040);
		endcase
	endfunction

	function automatic logic [31:0] random_component();
		case ($urandom_range(0, 4))
			0: return 32'($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
			1: return 32'($signed(16'($urandom)));
			default: return $urandom;
		endcase
	endfunction

	// stimulus
	initial begin
		eavr_pkg::req_t q;
		error_count = 0;
		arst_n = 1'b0;
		add_item(0, 0, 0, 65536, 131072, -65536);
		add_item(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		add_item(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
		add_item(0, 0, 5760, 32'h7fffffff, 32'h7fffffff, 0);
		add_item(0, 0, -5760, 32'h80000000, 32'h7fffffff, 0);
		add_item(5760, 5760, 5760, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		add_item(-32768, -32768, -32768, 32'h12345678, -32'h1234567, 32'h00010000);
		add_item(32767, 32767, 32767, -65536, 65536, 98304);
		add_item(23040, -23040, 23040, 65536, 65536, 65536);
		add_item(11520, 0, 0, 0, 65536, 65536);
		add_item(0, 11520, 0, 65536, 0, 65536);
		add_item(0, 0, 11520, 65536, 65536, 0);
		add_item(5761, 5759, 11519, 1000000, -1000000, 500000);
		add_item(46080, -46080, 34560, 65536, 65536, 65536);
		add_item(-11520, -5760, 17280, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		add_item(1, -1, 11521, 1, -1, 1);
		add_item(0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 1100; i++) begin
			q.roll_angle  = random_angle();
			q.pitch_angle = random_angle();
			q.yaw_angle   = random_angle();
			q.nav_x       = random_component();
			q.nav_y       = random_component();
			q.nav_z       = random_component();
			pending_req.push_back(q);
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_req.size() == 0 && !req_valid && expected_body.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_body.size() == 0 && !rsp_valid)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// sender
	initial begin
		req_valid = 1'b0;
		req_data = '0;
		send_gap = 0;
		zero_gap_mode = 1'b0;
	end

	always @(negedge clk) begin
		logic next_valid;
		if (arst_n && !(req_valid && !req_taken)) begin
			next_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (pending_req.size() > 0) begin
				req_data <= pending_req.pop_front();
				next_valid = 1'b1;
				if (pending_req.size() % 100 == 0)
					zero_gap_mode <= ($urandom_range(0, 2) == 0);
				send_gap <= zero_gap_mode ? 0 : $urandom_range(0, 6);
			end
			req_valid <= next_valid;
		end
	end

	// receiver, with one long hold-off to back the pipeline up
	initial begin
		rsp_ready = 1'b0;
		recv_wait = 0;
		long_hold = 0;
		long_hold_done = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && results_seen == 300) begin
				long_hold_done <= 1'b1;
				long_hold <= 200;
				rsp_ready <= 1'b0;
			end else if (long_hold > 0) begin
				long_hold <= long_hold - 1;
			end else if (rsp_taken || !rsp_ready) begin
				if (rsp_taken && !zero_gap_mode) begin
					recv_wait <= $urandom_range(0, 6);
					rsp_ready <= 1'b0;
				end else if (recv_wait > 0) begin
					recv_wait <= recv_wait - 1;
					rsp_ready <= 1'b0;
				end else begin
					rsp_ready <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		eavr_pkg::rsp_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
			rsp_taken <= 1'b0;
			idle_cycles <= 0;
			results_seen <= 0;
		end else begin
			req_taken <= req_valid && req_ready;
			rsp_taken <= rsp_valid && rsp_ready;
			if (req_valid && req_ready)
				expected_body.push_back(rotate_to_body(req_data));
			if (rsp_valid && rsp_ready) begin
				results_seen <= results_seen + 1;
				if (expected_body.size() == 0) begin
					$display("unexpected transaction on response channel");
					error_count++;
				end else begin
					want = expected_body.pop_front();
					if (rsp_data.body_x !== want.body_x)
						report_mismatch("body_x", rsp_data.body_x, want.body_x);
					if (rsp_data.body_y !== want.body_y)
						report_mismatch("body_y", rsp_data.body_y, want.body_y);
					if (rsp_data.body_z !== want.body_z)
						report_mismatch("body_z", rsp_data.body_z, want.body_z);
				end
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule

@@ filelist.f @@
design/eavr_pkg.sv
design/eavr_trig.sv
design/eavr_dcm.sv
design/eavr_dot.sv
design/euler_attitude_vector_rotate.sv
test/tb_euler_attitude_vector_rotate.sv
